// ===== rtl/scs_pkg.sv =====
// Package with the types, character codes and step helpers of the comment stripper.
package scs_pkg;

  // Character codes that steer the scanner.
  localparam logic [7:0] ChQuote  = 8'h27;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChLparen = 8'h28;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChRparen = 8'h29;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChCr     = 8'h0D;

  // Depth of the result queue and the width of its pointers and fill count.
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CntW      = $clog2(FifoDepth + 1);

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_STRING = 3'd1,
    MODE_LINE   = 3'd2,
    MODE_BLOCK  = 3'd3,
    MODE_BSTAR  = 3'd4
  } scan_mode_e;

  typedef enum logic [1:0] {
    HELD_NONE  = 2'd0,
    HELD_SLASH = 2'd1,
    HELD_PAREN = 2'd2
  } held_opener_e;

  // Scanner state carried from one byte to the next.
  typedef struct packed {
    scan_mode_e   mode;
    held_opener_e held;
    logic         prev_bs;
  } scs_state_t;

  localparam scs_state_t StateReset = '{mode: MODE_NORMAL, held: HELD_NONE, prev_bs: 1'b0};

  // One result item.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       end_of_text;
  } scs_result_t;

  // Results produced by one input byte, in order, and how many there are.
  typedef struct packed {
    scs_result_t [1:0] res;
    logic [1:0]        num;
  } scs_step_t;

  // Append one text byte to a step's results; a third byte is dropped.
  function automatic scs_step_t put_byte(scs_step_t s, logic [7:0] b);
    scs_step_t r;
    r = s;
    if (s.num < 2'd2) begin
      r.res[s.num[0]] = '{out_byte: b, out_valid: 1'b1, end_of_text: 1'b0};
      r.num           = s.num + 2'd1;
    end
    return r;
  endfunction

  // Byte code of a held opener.
  function automatic logic [7:0] held_char(held_opener_e h);
    logic [7:0] c;
    c = (h == HELD_SLASH) ? ChSlash : ChLparen;
    return c;
  endfunction

endpackage

// ===== rtl/scs_in_if.sv =====
// Input channel of the comment stripper: one raw source byte per transfer.
interface scs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;

  modport source (output valid, output in_byte, output last_byte, input ready);
  modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

// ===== rtl/scs_out_if.sv =====
// Output channel of the comment stripper: one result item per transfer.
interface scs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       end_of_text;

  modport source (output valid, output out_byte, output out_valid, output end_of_text,
                  input ready);
  modport sink   (input valid, input out_byte, input out_valid, input end_of_text,
                  output ready);
endinterface

// ===== rtl/scs_step.sv =====
// Combinational scan step: next state and up to two results for one input byte.
module scs_step (
  input  scs_pkg::scs_state_t state_i,
  input  logic [7:0]          in_byte_i,
  input  logic                last_byte_i,
  output scs_pkg::scs_state_t state_o,
  output scs_pkg::scs_step_t  step_o
);

  scs_pkg::scs_state_t st;
  scs_pkg::scs_step_t  sp;
  logic                quote_open;

  // A quote after a raw backslash is escaped and does not toggle a string.
  assign quote_open = (in_byte_i == scs_pkg::ChQuote) && !state_i.prev_bs;

  always_comb begin
    st = state_i;
    sp = '0;

    // Mode dependent handling of the byte.
    case (state_i.mode)
      scs_pkg::MODE_STRING: begin
        sp = scs_pkg::put_byte(sp, in_byte_i);
        if (quote_open) begin
          st.mode = scs_pkg::MODE_NORMAL;
        end
      end
      scs_pkg::MODE_LINE: begin
        if (in_byte_i == scs_pkg::ChLf || in_byte_i == scs_pkg::ChCr) begin
          sp      = scs_pkg::put_byte(sp, in_byte_i);
          st.mode = scs_pkg::MODE_NORMAL;
        end
      end
      scs_pkg::MODE_BLOCK: begin
        if (in_byte_i == scs_pkg::ChStar) begin
          st.mode = scs_pkg::MODE_BSTAR;
        end
      end
      scs_pkg::MODE_BSTAR: begin
        if (in_byte_i == scs_pkg::ChRparen) begin
          st.mode = scs_pkg::MODE_NORMAL;
        end else if (in_byte_i != scs_pkg::ChStar) begin
          st.mode = scs_pkg::MODE_BLOCK;
        end
      end
      default: begin
        st.mode = scs_pkg::MODE_NORMAL;
        if (state_i.held == scs_pkg::HELD_SLASH && in_byte_i == scs_pkg::ChSlash) begin
          st.held = scs_pkg::HELD_NONE;
          st.mode = scs_pkg::MODE_LINE;
        end else if (state_i.held == scs_pkg::HELD_PAREN && in_byte_i == scs_pkg::ChStar) begin
          st.held = scs_pkg::HELD_NONE;
          st.mode = scs_pkg::MODE_BLOCK;
        end else begin
          // Release the held opener; the byte then opens a string, is held, or passes as text.
          if (state_i.held != scs_pkg::HELD_NONE) begin
            sp = scs_pkg::put_byte(sp, scs_pkg::held_char(state_i.held));
          end
          st.held = scs_pkg::HELD_NONE;
          if (quote_open) begin
            st.mode = scs_pkg::MODE_STRING;
            sp      = scs_pkg::put_byte(sp, in_byte_i);
          end else if (in_byte_i == scs_pkg::ChSlash) begin
            st.held = scs_pkg::HELD_SLASH;
          end else if (in_byte_i == scs_pkg::ChLparen) begin
            st.held = scs_pkg::HELD_PAREN;
          end else begin
            sp = scs_pkg::put_byte(sp, in_byte_i);
          end
        end
      end
    endcase

    st.prev_bs = (in_byte_i == scs_pkg::ChBslash);

    // The last byte flushes a held opener, marks the final result and resets the scan.
    if (last_byte_i) begin
      if (st.held != scs_pkg::HELD_NONE) begin
        sp = scs_pkg::put_byte(sp, scs_pkg::held_char(st.held));
      end
      if (sp.num == 2'd0) begin
        sp.res[0] = '0;
        sp.num    = 2'd1;
      end
      sp.res[sp.num[1]].end_of_text = 1'b1;
      st = scs_pkg::StateReset;
    end
  end

  assign state_o = st;
  assign step_o  = sp;

endmodule

// ===== rtl/source_comment_stripper.sv =====
// Top level of the comment stripper: input register, scan step and result queue.
// A byte's results are offered once it has passed the input register and the result
// queue; a held slash or open paren comes out with the results of the byte after it.
// Throughput: one byte per cycle while the queue has room for two results; a byte with
// two results drains through the single-result port of the four-entry result queue.
// Reset: rst_ni clears the scan state, the input valid flag and the queue state at once.
module source_comment_stripper (
  input  logic       clk_i,
  input  logic       rst_ni,
  scs_in_if.sink     in_i,
  scs_out_if.source  out_o
);

  // Input register.
  logic                      in_vld_q;
  logic [7:0]                in_byte_q;
  logic                      in_last_q;

  // Scan state and step results.
  scs_pkg::scs_state_t       state_q, state_d;
  scs_pkg::scs_step_t        step;

  // Result queue.
  scs_pkg::scs_result_t      fifo_q [scs_pkg::FifoDepth];
  logic [scs_pkg::PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [scs_pkg::CntW-1:0]  cnt_q;
  logic [scs_pkg::PtrW-1:0]  wr_ptr_nx;

  logic fire;
  logic pop;
  logic in_xfer;

  // The byte in the input register is scanned once the queue has room for two results.
  assign fire    = in_vld_q && (cnt_q <= scs_pkg::CntW'(scs_pkg::FifoDepth - 2));
  assign pop     = out_o.valid && out_o.ready;
  assign in_i.ready = !in_vld_q || fire;
  assign in_xfer = in_i.valid && in_i.ready;

  scs_step u_step (
    .state_i     (state_q),
    .in_byte_i   (in_byte_q),
    .last_byte_i (in_last_q),
    .state_o     (state_d),
    .step_o      (step)
  );

  // Input register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_byte_q <= in_i.in_byte;
      in_last_q <= in_i.last_byte;
    end
  end

  // Scan state advances with each scanned byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= scs_pkg::StateReset;
    end else if (fire) begin
      state_q <= state_d;
    end
  end

  // Queue pointers and fill count.
  assign wr_ptr_nx = wr_ptr_q + scs_pkg::PtrW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (fire) begin
        wr_ptr_q <= wr_ptr_q + scs_pkg::PtrW'(step.num);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + scs_pkg::PtrW'(1);
      end
      cnt_q <= cnt_q + (fire ? scs_pkg::CntW'(step.num) : '0) - scs_pkg::CntW'(pop);
    end
  end

  // Queue storage takes up to two results per scanned byte.
  always_ff @(posedge clk_i) begin
    if (fire && step.num != 2'd0) begin
      fifo_q[wr_ptr_q] <= step.res[0];
    end
    if (fire && step.num == 2'd2) begin
      fifo_q[wr_ptr_nx] <= step.res[1];
    end
  end

  // Head of the queue drives the output channel.
  assign out_o.valid       = (cnt_q != '0);
  assign out_o.out_byte    = fifo_q[rd_ptr_q].out_byte;
  assign out_o.out_valid   = fifo_q[rd_ptr_q].out_valid;
  assign out_o.end_of_text = fifo_q[rd_ptr_q].end_of_text;

  // The queue never holds more results than it has entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= scs_pkg::CntW'(scs_pkg::FifoDepth))
    else $error("result queue overflow");

  // An opener is only ever held in normal text.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.held != scs_pkg::HELD_NONE |-> state_q.mode == scs_pkg::MODE_NORMAL)
    else $error("opener held outside normal text");

  // A last byte always yields at least one result and leaves the scanner reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && in_last_q |-> step.num != 2'd0)
    else $error("last byte produced no result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && in_last_q |=> state_q == scs_pkg::StateReset)
    else $error("scan state not reset after last byte");

  // Only the final result of a step may carry the end marker.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && step.num == 2'd2 |-> !step.res[0].end_of_text)
    else $error("end marker on a non-final result");

endmodule
